// ----- src/skset_pkg.sv -----
`default_nettype none
package skset_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned IN_W    = 40;
  localparam int unsigned OUT_W   = 16;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } ctl_state_t;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- src/skset_cell.sv -----
`default_nettype none
module skset_cell (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cmp_en,
  input  skset_pkg::key_t       cmp_key,
  input  skset_pkg::cell_cmd_t  cmd,
  input  skset_pkg::key_t       ins_key,
  input  skset_pkg::key_t       lo_key,
  input  wire                   lo_valid,
  input  wire                   lo_lt,
  input  skset_pkg::key_t       hi_key,
  input  wire                   hi_valid,
  output skset_pkg::key_t       key_r,
  output logic                  valid_r,
  output logic                  lt_r,
  output logic                  eq_r
);
  import skset_pkg::*;

  key_t key_nxt;
  logic valid_nxt;
  logic lt_nxt;
  logic eq_nxt;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    if (cmp_en) begin
      lt_nxt = valid_r && (key_r < cmp_key);
      eq_nxt = valid_r && (key_r == cmp_key);
    end
    // cells at or above the key position shift
    if (cmd.ins && !lt_r) begin
      if (lo_lt) begin
        key_nxt   = ins_key;
        valid_nxt = 1'b1;
      end else begin
        key_nxt   = lo_key;
        valid_nxt = lo_valid;
      end
    end else if (cmd.del && !lt_r) begin
      key_nxt   = hi_key;
      valid_nxt = hi_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule
`default_nettype wire

// ----- src/sorted_key_set.sv -----
`default_nettype none
// Sorted set of distinct signed 32-bit keys held in a row of CAPACITY cells,
// ascending from cell 0. Each input word carries an operation (lookup, insert,
// delete) and a key; each produces exactly one result word with success, a
// refused-because-full flag and the key count after the operation (low 7 bits).
// An operation runs as a compare step and a shift step: every cell compares its
// key with the incoming key in the accept cycle, and in the apply step that
// follows the cells shift up (insert) or down (delete) by one place from the key
// position while the result is registered. No new word is taken until the last
// has shifted; a waiting result holds back only the shift step of the next word.
module sorted_key_set #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // [1:0] operation, [33:2] key, zero fill above
  input  wire  [skset_pkg::IN_W-1:0]   in_tdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // [0] success, [1] full_refused, [8:2] stored_count, zero fill above
  output logic [skset_pkg::OUT_W-1:0]  out_tdata
);
  import skset_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  ctl_state_t            state_r, state_nxt;
  logic [OP_W-1:0]       op_r;
  key_t                  key_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_tvalid_r;
  logic [OUT_W-1:0]      out_data_r;

  logic                  accept;
  logic                  apply_go;
  logic                  held;
  logic                  full;
  logic                  do_ins;
  logic                  do_del;
  logic                  success;
  logic                  refused;
  cell_cmd_t             cmd;
  key_t                  in_key;

  key_t                  cell_key   [CAPACITY];
  logic [CAPACITY-1:0]   cell_valid;
  logic [CAPACITY-1:0]   cell_lt;
  logic [CAPACITY-1:0]   cell_eq;

  assign in_key = key_t'(in_tdata[OP_W +: KEY_W]);
  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    apply_go  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!out_tvalid_r || out_tready) begin
          apply_go  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign held    = |cell_eq;
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign do_ins  = (op_r == OP_INSERT) && !held && !full;
  assign do_del  = (op_r == OP_DELETE) && held;
  assign success = ((op_r == OP_LOOKUP) && held) || do_ins || do_del;
  assign refused = (op_r == OP_INSERT) && !held && full;

  assign cmd.ins = apply_go && do_ins;
  assign cmd.del = apply_go && do_del;

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t lo_key;
    logic lo_valid;
    logic lo_lt;
    key_t hi_key;
    logic hi_valid;

    if (i == 0) begin : g_first
      assign lo_key   = '0;
      assign lo_valid = 1'b0;
      assign lo_lt    = 1'b1;
    end else begin : g_mid_lo
      assign lo_key   = cell_key[i-1];
      assign lo_valid = cell_valid[i-1];
      assign lo_lt    = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign hi_key   = '0;
      assign hi_valid = 1'b0;
    end else begin : g_mid_hi
      assign hi_key   = cell_key[i+1];
      assign hi_valid = cell_valid[i+1];
    end

    skset_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmp_en   (accept),
      .cmp_key  (in_key),
      .cmd      (cmd),
      .ins_key  (key_r),
      .lo_key   (lo_key),
      .lo_valid (lo_valid),
      .lo_lt    (lo_lt),
      .hi_key   (hi_key),
      .hi_valid (hi_valid),
      .key_r    (cell_key[i]),
      .valid_r  (cell_valid[i]),
      .lt_r     (cell_lt[i]),
      .eq_r     (cell_eq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_go) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tdata[OP_W-1:0];
      key_r <= in_key;
    end
    if (apply_go) begin
      out_data_r <= {(OUT_W - COUNT_W - 2)'(0), COUNT_W'(count_nxt), refused, success};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
